FILE: rtl/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg: shared constants and types for the PNG row unfilter
// Filter codes, configuration register map, defaults and the result item.
// ----------------------------------------------------------------------------
package pru_pkg;

	// Default sizes of the previous-row store and the per-pixel history.
	localparam int MAX_ROW_BYTES   = 4096;
	localparam int MAX_PIXEL_BYTES = 16;

	// Configuration register map.
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 13;
	localparam logic [CFG_IW-1:0] CFG_COLORS  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_BPC     = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_COLUMNS = 2'd2;

	localparam int COLORS_W  = 4;
	localparam int BPC_W     = 5;
	localparam int COLUMNS_W = 13;

	localparam logic [COLORS_W-1:0]  COLORS_RST  = 4'd1;
	localparam logic [BPC_W-1:0]     BPC_RST     = 5'd8;
	localparam logic [COLUMNS_W-1:0] COLUMNS_RST = 13'd1;

	// Bits per pixel product (colors * bits_per_component) and its reset.
	localparam int PIX_BITS_W = COLORS_W + BPC_W;
	localparam logic [PIX_BITS_W-1:0] PIX_BITS_RST = 9'd8;

	// Round bits up to whole bytes.
	localparam int BYTE_ROUND = 7;
	localparam int BYTE_SHIFT = 3;

	// Row filter codes; anything above PAETH in a tag maps to BAD.
	localparam int FILT_W = 3;
	localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
	localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
	localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
	localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
	localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;
	localparam logic [FILT_W-1:0] FILT_BAD   = 3'd5;

	typedef struct packed {
		logic       bad;
		logic       last;
		logic [7:0] data;
	} out_item_t;

endpackage

FILE: rtl/png_row_unfilter.sv
// ----------------------------------------------------------------------------
// png_row_unfilter: PNG row filter reconstruction (None/Sub/Up/Average/Paeth)
// Byte-serial unfilter with the previous row held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  -------------------------------------
//  s_*       in   s_tvalid / s_tready  s_tdata  = filtered_byte
//  m_*       out  m_tvalid / m_tready  m_tdata  = plain_byte, m_tlast = row_end,
//                                      m_tuser  = bad_filter
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index 0 colors, 1 bits_per_component,
//                                      2 columns; cfg_data = value
//
//  One byte per cycle sustained while no config write settles and the output
//  queue has room. A data byte reads the previous row in the accept cycle, is
//  reconstructed and written back in the cycle after. Tag bytes give no result.
//  Reset needs no clearing pass: a fill count marks how much of the row RAM
//  has been written, and unwritten entries read as zero.
//  After a config write the input holds off while bytes per pixel and row
//  length settle, then while the history slot of a row in progress is rebuilt
//  one position bit at a time.
//  A four-entry output queue lets requests keep flowing while results wait.
// ----------------------------------------------------------------------------
module png_row_unfilter
	import pru_pkg::*;
#(
	parameter int MAX_ROW_BYTES   = pru_pkg::MAX_ROW_BYTES,
	parameter int MAX_PIXEL_BYTES = pru_pkg::MAX_PIXEL_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] filtered_byte
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] plain_byte
	output logic              m_tlast,   // row_end
	output logic              m_tuser,   // [0] bad_filter
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam int AW  = $clog2(MAX_ROW_BYTES);       // row RAM address
	localparam int RBW = $clog2(MAX_ROW_BYTES + 1);   // row length / fill count
	localparam int PBW = $clog2(MAX_PIXEL_BYTES + 1); // bytes per pixel
	localparam int SW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int RMW = PBW + 1;
	localparam int CW  = $clog2(AW + 3);
	localparam int PROD_W = COLUMNS_W + PIX_BITS_W;

	// ------------------------------------------------------------------
	// Configuration registers and derived sizes
	// ------------------------------------------------------------------
	logic [COLORS_W-1:0]   colors_q;
	logic [BPC_W-1:0]      bpc_q;
	logic [COLUMNS_W-1:0]  columns_q;
	logic [PIX_BITS_W-1:0] pix_bits_q;
	logic [PBW-1:0]        bpp_q;
	logic [RBW-1:0]        rb_q;
	logic [CW-1:0]         cnt_q;      // settle / slot rebuild countdown
	logic [AW-1:0]         sh_q;       // position bits for the remainder
	logic [PBW-1:0]        rem_q;

	logic                  cfg_wr;
	logic [PROD_W-1:0]     row_bits;
	logic [PROD_W:0]       row_bits_rnd;
	logic [PIX_BITS_W:0]   pix_bits_rnd;
	logic [PIX_BITS_W-BYTE_SHIFT:0] bpp_raw;
	logic [PROD_W-BYTE_SHIFT:0]     rb_raw;
	logic [PBW-1:0]        bpp_n;
	logic [RBW-1:0]        rb_n;
	logic [RMW-1:0]        rem_sh;
	logic [RMW-1:0]        rem_n;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		pix_bits_rnd = (PIX_BITS_W+1)'(pix_bits_q) + (PIX_BITS_W+1)'(BYTE_ROUND);
		bpp_raw      = pix_bits_rnd[PIX_BITS_W:BYTE_SHIFT];
		row_bits     = PROD_W'(columns_q) * PROD_W'(pix_bits_q);
		row_bits_rnd = (PROD_W+1)'(row_bits) + (PROD_W+1)'(BYTE_ROUND);
		rb_raw       = row_bits_rnd[PROD_W:BYTE_SHIFT];
		if (bpp_raw == '0) begin
			bpp_n = PBW'(1);
		end else if (32'(bpp_raw) > MAX_PIXEL_BYTES) begin
			bpp_n = PBW'(MAX_PIXEL_BYTES);
		end else begin
			bpp_n = PBW'(bpp_raw);
		end
		if (rb_raw == '0) begin
			rb_n = RBW'(1);
		end else if (32'(rb_raw) > MAX_ROW_BYTES) begin
			rb_n = RBW'(MAX_ROW_BYTES);
		end else begin
			rb_n = RBW'(rb_raw);
		end
		// one restoring step of (row position mod bytes per pixel)
		rem_sh = {rem_q, sh_q[AW-1]};
		if (rem_sh >= RMW'(bpp_q)) begin
			rem_n = rem_sh - RMW'(bpp_q);
		end else begin
			rem_n = rem_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q   <= COLORS_RST;
			bpc_q      <= BPC_RST;
			columns_q  <= COLUMNS_RST;
			pix_bits_q <= PIX_BITS_RST;
			bpp_q      <= PBW'(1);
			rb_q       <= RBW'(1);
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_COLORS:  colors_q  <= cfg_data[COLORS_W-1:0];
					CFG_BPC:     bpc_q     <= cfg_data[BPC_W-1:0];
					CFG_COLUMNS: columns_q <= cfg_data[COLUMNS_W-1:0];
					default: ;
				endcase
			end
			pix_bits_q <= PIX_BITS_W'(colors_q) * PIX_BITS_W'(bpc_q);
			bpp_q      <= bpp_n;
			rb_q       <= rb_n;
		end
	end

	// ------------------------------------------------------------------
	// Row position state (stage 0: accept and RAM read)
	// ------------------------------------------------------------------
	logic              in_row_q;   // 0: next byte is a tag
	logic [FILT_W-1:0] kind_q;
	logic [AW-1:0]     d_q;        // next data byte position
	logic [SW-1:0]     slot_q;     // d_q mod bytes per pixel

	logic              s_acc;
	logic              data_acc;
	logic              row_last;
	logic [SW-1:0]     slot_next;
	logic [2:0]        fcnt_q;
	logic              vld_s1;

	assign s_tready = (cnt_q == '0) && ((32'(fcnt_q) + 32'(vld_s1)) <= 2);
	assign s_acc    = s_tvalid && s_tready;
	assign data_acc = s_acc && in_row_q;
	assign row_last = (32'(d_q) + 1) >= 32'(rb_q);
	assign slot_next = ((32'(slot_q) + 1) == 32'(bpp_q)) ? '0 : slot_q + SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= 1'b0;
			kind_q   <= FILT_NONE;
			d_q      <= '0;
			slot_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_wr) begin
				cnt_q <= CW'(AW + 2);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cnt_q == CW'(1)) begin
				slot_q <= SW'(rem_n);
			end
			if (s_acc) begin
				if (!in_row_q) begin
					kind_q   <= (s_tdata <= 8'(FILT_PAETH)) ? s_tdata[FILT_W-1:0] : FILT_BAD;
					in_row_q <= 1'b1;
					d_q      <= '0;
					slot_q   <= '0;
				end else if (row_last) begin
					in_row_q <= 1'b0;
				end else begin
					d_q    <= d_q + AW'(1);
					slot_q <= slot_next;
				end
			end
		end
	end

	// slot rebuild after a config write, one position bit per cycle
	always_ff @(posedge clk) begin
		if (cnt_q == CW'(AW + 1)) begin
			sh_q  <= d_q;
			rem_q <= '0;
		end else begin
			sh_q  <= sh_q << 1;
			rem_q <= PBW'(rem_n);
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: prediction, reconstruction, write-back
	// ------------------------------------------------------------------
	logic [AW-1:0]     d_s1;
	logic [SW-1:0]     slot_s1;
	logic              ge_s1;     // position at least one pixel into the row
	logic [FILT_W-1:0] kind_s1;
	logic [7:0]        x_s1;
	logic              end_s1;

	logic [7:0]        ram_rdata;
	logic [RBW-1:0]    fill_q;
	logic [7:0]        left_q   [MAX_PIXEL_BYTES];
	logic [7:0]        upleft_q [MAX_PIXEL_BYTES];

	logic [7:0]        a_v, b_v, c_v, pred, v_s1;
	logic              bad_s1;
	logic signed [9:0] dbc, dac, dabc;
	logic [9:0]        pa, pb, pc;

	pru_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_BYTES)
	) u_prior_row (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (d_s1),
		.wdata (v_s1),
		.re    (data_acc),
		.raddr (d_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= data_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			d_s1    <= d_q;
			slot_s1 <= slot_q;
			ge_s1   <= 32'(d_q) >= 32'(bpp_q);
			kind_s1 <= kind_q;
			x_s1    <= s_tdata;
			end_s1  <= row_last;
		end
	end

	always_comb begin
		// entries past the fill count were never written: read as zero
		b_v = (32'(d_s1) < 32'(fill_q)) ? ram_rdata : 8'd0;
		a_v = ge_s1 ? left_q[slot_s1]   : 8'd0;
		c_v = ge_s1 ? upleft_q[slot_s1] : 8'd0;

		dbc  = $signed({2'b00, b_v}) - $signed({2'b00, c_v});
		dac  = $signed({2'b00, a_v}) - $signed({2'b00, c_v});
		dabc = $signed({2'b00, a_v}) + $signed({2'b00, b_v}) - $signed({1'b0, c_v, 1'b0});
		pa   = (dbc  < 0) ? 10'(-dbc)  : 10'(dbc);
		pb   = (dac  < 0) ? 10'(-dac)  : 10'(dac);
		pc   = (dabc < 0) ? 10'(-dabc) : 10'(dabc);

		bad_s1 = 1'b0;
		case (kind_s1)
			FILT_NONE: pred = 8'd0;
			FILT_SUB:  pred = a_v;
			FILT_UP:   pred = b_v;
			FILT_AVG:  pred = 8'((9'(a_v) + 9'(b_v)) >> 1);
			FILT_PAETH: begin
				// ties go left, then up, then up-left
				if (pa <= pb && pa <= pc) begin
					pred = a_v;
				end else if (pb <= pc) begin
					pred = b_v;
				end else begin
					pred = c_v;
				end
			end
			default: begin
				pred   = 8'd0;
				bad_s1 = 1'b1;
			end
		endcase
		v_s1 = x_s1 + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else if (vld_s1) begin
			left_q[slot_s1]   <= v_s1;
			upleft_q[slot_s1] <= b_v;
			if (32'(d_s1) == 32'(fill_q)) begin
				fill_q <= fill_q + RBW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Output queue
	// ------------------------------------------------------------------
	logic [1:0] wr_ptr_q, rd_ptr_q;
	out_item_t  oq_q [4];
	out_item_t  head;
	logic       pop;

	assign head     = oq_q[rd_ptr_q];
	assign m_tvalid = fcnt_q != '0;
	assign m_tdata  = head.data;
	assign m_tlast  = head.last;
	assign m_tuser  = head.bad;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			oq_q[wr_ptr_q] <= '{bad: bad_s1, last: end_s1, data: v_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (vld_s1) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			case ({vld_s1, pop})
				2'b10:   fcnt_q <= fcnt_q + 3'd1;
				2'b01:   fcnt_q <= fcnt_q - 3'd1;
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// a read and the write-back never hit the same row entry in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(data_acc && vld_s1) |-> (d_q != d_s1))
		else $error("row RAM read and write to the same entry");

	// the queue never overflows: queued plus in-flight stays within depth
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(fcnt_q) + 32'(vld_s1)) <= 4)
		else $error("output queue overflow");

	// a tag byte produces no stage-1 work
	a_tag_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !in_row_q) |=> !vld_s1)
		else $error("tag byte entered reconstruction");

	// history slot stays below bytes per pixel once sizes have settled
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 && in_row_q) |-> (32'(slot_q) < 32'(bpp_q)))
		else $error("history slot out of range");

endmodule

FILE: rtl/pru_ram.sv
// ----------------------------------------------------------------------------
// pru_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: verif/pru_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pru_checker: byte reconstruction predictor and result compare
// Keeps its own row store, pixel history and register copies, predicts each
// output byte from accepted requests and checks results in order.
// ----------------------------------------------------------------------------
module pru_checker
	import pru_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,
	input  logic              m_tlast,
	input  logic              m_tuser,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output int                mismatches,
	output int                pending
);

	logic [COLORS_W-1:0]  colors_q;
	logic [BPC_W-1:0]     bpc_q;
	logic [COLUMNS_W-1:0] columns_q;

	logic [7:0]        row_store [MAX_ROW_BYTES];
	logic [7:0]        left_px   [MAX_PIXEL_BYTES];
	logic [7:0]        upleft_px [MAX_PIXEL_BYTES];
	logic [FILT_W-1:0] row_filter;
	int unsigned       row_pos;     // 0: tag next, k: data byte k-1 next

	out_item_t recon_q [$];
	int        err_cnt = 0;

	assign mismatches = err_cnt;

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		err_cnt++;
		$display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
	endtask

	function automatic logic [7:0] paeth_pick(input int a, input int b, input int c);
		int pa, pb, pc;
		pa = (b > c) ? b - c : c - b;
		pb = (a > c) ? a - c : c - a;
		pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
		if (pa <= pb && pa <= pc)
			return 8'(a);
		if (pb <= pc)
			return 8'(b);
		return 8'(c);
	endfunction

	task automatic unfilter_byte(input logic [7:0] x);
		int unsigned px_bytes, line_len, d, slot, a, b, c, pred;
		out_item_t   item;
		if (row_pos == 0) begin
			row_filter = (x <= 8'(FILT_PAETH)) ? x[FILT_W-1:0] : FILT_BAD;
			row_pos    = 1;
			return;
		end
		px_bytes = (int'(colors_q) * int'(bpc_q) + 7) / 8;
		if (px_bytes == 0)
			px_bytes = 1;
		if (px_bytes > MAX_PIXEL_BYTES)
			px_bytes = MAX_PIXEL_BYTES;
		line_len = (int'(columns_q) * int'(colors_q) * int'(bpc_q) + 7) / 8;
		if (line_len == 0)
			line_len = 1;
		if (line_len > MAX_ROW_BYTES)
			line_len = MAX_ROW_BYTES;

		d = row_pos - 1;
		if (d >= MAX_ROW_BYTES)
			d = MAX_ROW_BYTES - 1;
		slot = d % px_bytes;
		// first pixel of a row has no left neighbors
		a = (d >= px_bytes) ? left_px[slot] : 0;
		c = (d >= px_bytes) ? upleft_px[slot] : 0;
		b = row_store[d];

		item.bad = 1'b0;
		case (row_filter)
			FILT_NONE:  pred = 0;
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = (a + b) >> 1;
			FILT_PAETH: pred = paeth_pick(a, b, c);
			default: begin
				pred     = 0;
				item.bad = 1'b1;
			end
		endcase
		item.data = 8'(x + pred);

		left_px[slot]   = item.data;
		upleft_px[slot] = row_store[d];
		row_store[d]    = item.data;

		item.last = (d + 1 >= line_len);
		row_pos   = item.last ? 0 : d + 2;
		recon_q.push_back(item);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			colors_q  = COLORS_RST;
			bpc_q     = BPC_RST;
			columns_q = COLUMNS_RST;
			foreach (row_store[i])
				row_store[i] = 8'h00;
			foreach (left_px[i]) begin
				left_px[i]   = 8'h00;
				upleft_px[i] = 8'h00;
			end
			row_filter = FILT_NONE;
			row_pos    = 0;
			recon_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (recon_q.size() == 0) begin
					report("unexpected result", m_tdata, 8'h00);
				end else begin
					want = recon_q.pop_front();
					if (m_tdata !== want.data)
						report("plain_byte", m_tdata, want.data);
					if (m_tlast !== want.last)
						report("row_end", 8'(m_tlast), 8'(want.last));
					if (m_tuser !== want.bad)
						report("bad_filter", 8'(m_tuser), 8'(want.bad));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COLORS:  colors_q  = cfg_data[COLORS_W-1:0];
					CFG_BPC:     bpc_q     = cfg_data[BPC_W-1:0];
					CFG_COLUMNS: columns_q = cfg_data[COLUMNS_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				unfilter_byte(s_tdata);
			pending <= recon_q.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for png_row_unfilter
// Directed rows over every filter but None, a pair of rows at the widest pixel, then
// random settings and rows with request and result stalls; pru_checker
// compares.
// ----------------------------------------------------------------------------
module tb_top;
	import pru_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_BYTES = 1000;
	localparam int QUIET_CYCLES = 8;   // lets an in-flight result land

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata   = 8'h00;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [7:0]        m_tdata;
	logic              m_tlast;
	logic              m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = CFG_COLORS;
	logic [CFG_DW-1:0] cfg_data  = '0;

	int mismatches;
	int pending;

	// no random stalls on either side while set
	logic        steady      = 1'b0;
	int unsigned sent_bytes  = 0;
	int unsigned cycle_cnt   = 0;
	// data bytes of a row left open before a settings change
	int unsigned carry_bytes = 0;

	// register values as last written
	logic [COLORS_W-1:0]  cur_colors  = COLORS_RST;
	logic [BPC_W-1:0]     cur_bpc     = BPC_RST;
	logic [COLUMNS_W-1:0] cur_columns = COLUMNS_RST;

	png_row_unfilter dut (.*);

	pru_checker recon_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result-side stalls and the run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		m_tready  <= steady || ($urandom_range(99) >= 6);
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// row length in bytes for the current settings, used to shape rows
	function automatic int unsigned row_len();
		int unsigned r;
		r = (int'(cur_columns) * int'(cur_colors) * int'(cur_bpc) + 7) / 8;
		if (r == 0)
			r = 1;
		if (r > MAX_ROW_BYTES)
			r = MAX_ROW_BYTES;
		return r;
	endfunction

	// mostly legal filter tags, now and then an unknown one
	function automatic logic [7:0] row_tag();
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255, 5));
		return 8'($urandom_range(FILT_PAETH, FILT_NONE));
	endfunction

	// one request on the input stream; valid stays up across back-to-back bytes
	task automatic send_byte(input logic [7:0] b);
		if (!steady && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_bytes++;
	endtask

	task automatic send_row(input logic [7:0] tag, input int unsigned n);
		send_byte(tag);
		repeat (n) send_byte(8'($urandom_range(255)));
	endtask

	// hold off requests until every predicted byte has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// idle block: drained, and a tag byte in flight has had time to land
	task automatic settle();
		drain();
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic write_regs(input bit do_colors, input bit do_bpc, input bit do_columns);
		if (do_colors)
			put_reg(CFG_COLORS, CFG_DW'(cur_colors));
		if (do_bpc)
			put_reg(CFG_BPC, CFG_DW'(cur_bpc));
		if (do_columns)
			put_reg(CFG_COLUMNS, CFG_DW'(cur_columns));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned rb, k, pix, lim, rand_start;
		bit          wc, wb, wl;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings give one-byte rows; the first row reads a zero prior row.
		send_byte(8'(FILT_UP));
		send_byte(8'h80);

		// Three-byte rows, one byte per pixel: each filter but None over byte extremes.
		settle();
		cur_columns = 13'd3;
		write_regs(1'b0, 1'b0, 1'b1);
		send_byte(8'(FILT_SUB));
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'(FILT_UP));
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'(FILT_AVG));
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'(FILT_PAETH));
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hFF);
		// unknown tag: bytes pass through flagged
		send_byte(8'hFF);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(8'h00);

		// Shorten the row while two bytes in: the next byte closes it.
		send_byte(8'(FILT_AVG));
		send_byte(8'h10);
		send_byte(8'h20);
		settle();
		cur_columns = 13'd1;
		write_regs(1'b0, 1'b0, 1'b1);
		send_byte(8'h30);

		// Oversized component settings saturate to the widest pixel; one column
		// keeps the row short. Two rows so the second reads back the first.
		settle();
		cur_colors  = 4'd15;
		cur_bpc     = 5'd31;
		cur_columns = 13'd1;
		write_regs(1'b1, 1'b1, 1'b1);
		steady = 1'b1;
		send_row(8'(FILT_SUB), row_len());
		send_row(8'(FILT_PAETH), row_len());
		steady = 1'b0;

		// Random phases: new settings, a handful of short well-formed rows,
		// sometimes a row left open across the next settings change.
		rand_start = sent_bytes;
		while (sent_bytes - rand_start < RANDOM_BYTES) begin
			settle();
			wc = 1'b1;
			wb = 1'b1;
			wl = 1'b1;
			if ($urandom_range(3) == 0) begin
				wc = 1'($urandom_range(1));
				wb = 1'($urandom_range(1));
				wl = !(wc || wb) || $urandom_range(1);
			end
			if ($urandom_range(15) == 0) begin
				// zero and oversized fields
				cur_colors = $urandom_range(1) ? 4'd0 : 4'd15;
				case ($urandom_range(3))
					0: cur_bpc = 5'd0;
					1: cur_bpc = 5'd31;
					2: cur_bpc = 5'd1;
					default: cur_bpc = 5'd16;
				endcase
				cur_columns = COLUMNS_W'($urandom_range(3));
				write_regs(1'b1, 1'b1, 1'b1);
			end else begin
				if (wc)
					cur_colors = COLORS_W'($urandom_range(($urandom_range(3) == 0) ? 8 : 4, 1));
				if (wb)
					case ($urandom_range(4))
						0: cur_bpc = 5'd1;
						1: cur_bpc = 5'd2;
						2: cur_bpc = 5'd4;
						3: cur_bpc = 5'd8;
						default: cur_bpc = 5'd16;
					endcase
				// keep rows short
				if (wl || row_len() > 64) begin
					wl  = 1'b1;
					pix = int'(cur_colors) * int'(cur_bpc);
					lim = (pix == 0) ? 8 : 192 / pix;
					if (lim == 0)
						lim = 1;
					cur_columns = COLUMNS_W'($urandom_range(lim, 1));
				end
				write_regs(wc, wb, wl);
			end
			steady = ($urandom_range(5) == 0);
			rb     = row_len();

			// finish a row left open; at or past the new length one byte ends it
			if (carry_bytes != 0) begin
				repeat ((carry_bytes >= rb) ? 1 : rb - carry_bytes)
					send_byte(8'($urandom_range(255)));
				carry_bytes = 0;
			end

			repeat ($urandom_range(6, 1)) begin
				if ($urandom_range(9) == 0)
					drain();
				send_row(row_tag(), rb);
			end

			if (rb > 1 && $urandom_range(7) == 0) begin
				k = $urandom_range(rb - 1, 1);
				send_row(row_tag(), k);
				carry_bytes = k;
			end
		end
		steady = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/pru_pkg.sv
rtl/pru_ram.sv
rtl/png_row_unfilter.sv
verif/pru_checker.sv
verif/tb_top.sv
